>>> hdl/sitd_pkg.sv
package sitd_pkg;

  localparam int VALUE_W = 64;
  localparam int SCALE_W = 8;
  localparam int DIGITS = 20;
  localparam int CNT_W = 5;
  localparam int SHIFT_CNT_W = 7;
  localparam int MAX_SCALE_DEFAULT = 18;

  localparam logic signed [SCALE_W-1:0] LOWEST_SCALE = -8'sd18;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR = 8'h2A;

  typedef logic [DIGITS-1:0][3:0] bcd_t;

endpackage

>>> hdl/sitd_bcd.sv
module sitd_bcd (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [sitd_pkg::VALUE_W-1:0]    mag,
  output logic                            done,
  output logic [sitd_pkg::CNT_W-1:0]      nd,
  output sitd_pkg::bcd_t                  digits
);

  typedef enum logic [1:0] {C_IDLE, C_SHIFT, C_COUNT} cstate_t;

  cstate_t                                state;
  logic [sitd_pkg::VALUE_W-1:0]           mag_sr;
  logic [sitd_pkg::SHIFT_CNT_W-1:0]       cnt;
  sitd_pkg::bcd_t                         adj;
  logic [sitd_pkg::CNT_W-1:0]             lead;

  // add 3 to every digit of 5 or more before the shift (double dabble)
  always_comb begin
    for (int i = 0; i < sitd_pkg::DIGITS; i++) begin
      adj[i] = (digits[i] >= 4'd5) ? digits[i] + 4'd3 : digits[i];
    end
  end

  // digit count: position of the highest non-zero digit, plus one
  always_comb begin
    lead = '0;
    for (int i = 0; i < sitd_pkg::DIGITS; i++) begin
      if (digits[i] != 4'd0) begin
        lead = sitd_pkg::CNT_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start) begin
            mag_sr <= mag;
            digits <= '0;
            cnt <= '0;
            state <= C_SHIFT;
          end
        end
        C_SHIFT: begin
          digits <= {adj[sitd_pkg::DIGITS-1:0]} << 1 | sitd_pkg::bcd_t'(mag_sr[sitd_pkg::VALUE_W-1]);
          mag_sr <= mag_sr << 1;
          cnt <= cnt + 1'b1;
          if (cnt == sitd_pkg::SHIFT_CNT_W'(sitd_pkg::VALUE_W - 1)) begin
            state <= C_COUNT;
          end
        end
        C_COUNT: begin
          nd <= lead;
          done <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/scaled_int_to_decimal_text.sv
// The first character follows the input transfer after the 64 shift steps of the
// serial binary-to-BCD converter, the digit count and the sequencer load; then one
// character per cycle while m_tready is high, up to 21. Zero and the "***" case
// skip the converter and give their 1 or 3 characters at once.
// One item at a time: a new input is taken only once the last character is loaded.
// Synchronous active-high reset clears the control state; the port is idle after it.
module scaled_int_to_decimal_text #(
  parameter int MAX_SCALE = sitd_pkg::MAX_SCALE_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // [63:0] value, [71:64] scale
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] char_out
  output logic        m_tlast    // last
);

  typedef enum logic [1:0] {IDLE, CONV, EMIT, SPEC} state_t;

  localparam logic signed [sitd_pkg::SCALE_W-1:0] MAX_S = sitd_pkg::SCALE_W'(MAX_SCALE);

  state_t                             state;
  logic [sitd_pkg::VALUE_W-1:0]       value;
  logic signed [sitd_pkg::SCALE_W-1:0] scale;
  logic                               neg;
  logic [sitd_pkg::VALUE_W-1:0]       mag;
  logic [sitd_pkg::CNT_W-1:0]         s_eff_next;
  logic [sitd_pkg::CNT_W-1:0]         s_eff;
  logic                               conv_start;
  logic                               conv_done;
  logic [sitd_pkg::CNT_W-1:0]         nd;
  sitd_pkg::bcd_t                     digits;
  logic                               sign_pend;
  logic                               lead_dot;
  logic                               mid_dot;
  logic [sitd_pkg::CNT_W-1:0]         pad;
  logic [sitd_pkg::CNT_W-1:0]         idx;
  logic [1:0]                         spec_cnt;
  logic [7:0]                         spec_ch;
  logic                               out_free;

  assign value = s_tdata[sitd_pkg::VALUE_W-1:0];
  assign scale = signed'(s_tdata[sitd_pkg::VALUE_W +: sitd_pkg::SCALE_W]);
  assign neg = value[sitd_pkg::VALUE_W-1];
  // two's complement negate also gives the right magnitude for the most negative value
  assign mag = neg ? ('0 - value) : value;
  assign s_tready = (state == IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign conv_start = s_tvalid && s_tready && (value != '0) && !(scale < sitd_pkg::LOWEST_SCALE);

  always_comb begin
    if (scale > MAX_S) begin
      s_eff_next = sitd_pkg::CNT_W'(MAX_SCALE);
    end else if (scale < 0) begin
      s_eff_next = '0;
    end else begin
      s_eff_next = scale[sitd_pkg::CNT_W-1:0];
    end
  end

  sitd_bcd u_bcd (
    .clk    (clk),
    .rst    (rst),
    .start  (conv_start),
    .mag    (mag),
    .done   (conv_done),
    .nd     (nd),
    .digits (digits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      m_tvalid <= 1'b0;
      sign_pend <= 1'b0;
      lead_dot <= 1'b0;
      mid_dot <= 1'b0;
      pad <= '0;
      idx <= '0;
      spec_cnt <= '0;
    end else begin
      // EMIT and SPEC reload the output register whenever it is free
      if (m_tvalid && m_tready && state != EMIT && state != SPEC) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            sign_pend <= neg;
            s_eff <= s_eff_next;
            if (value == '0) begin
              spec_ch <= sitd_pkg::CH_ZERO;
              spec_cnt <= 2'd0;
              state <= SPEC;
            end else if (scale < sitd_pkg::LOWEST_SCALE) begin
              spec_ch <= sitd_pkg::CH_STAR;
              spec_cnt <= 2'd2;
              state <= SPEC;
            end else begin
              state <= CONV;
            end
          end
        end
        CONV: begin
          if (conv_done) begin
            idx <= nd - 1'b1;
            if (s_eff != '0 && nd <= s_eff) begin
              lead_dot <= 1'b1;
              mid_dot <= 1'b0;
              pad <= s_eff - nd;
            end else begin
              lead_dot <= 1'b0;
              mid_dot <= (s_eff != '0);
              pad <= '0;
            end
            state <= EMIT;
          end
        end
        EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            if (sign_pend) begin
              m_tdata <= sitd_pkg::CH_MINUS;
              m_tlast <= 1'b0;
              sign_pend <= 1'b0;
            end else if (lead_dot) begin
              m_tdata <= sitd_pkg::CH_POINT;
              m_tlast <= 1'b0;
              lead_dot <= 1'b0;
            end else if (pad != '0) begin
              m_tdata <= sitd_pkg::CH_ZERO;
              m_tlast <= 1'b0;
              pad <= pad - 1'b1;
            end else if (mid_dot && idx == s_eff - 1'b1) begin
              m_tdata <= sitd_pkg::CH_POINT;
              m_tlast <= 1'b0;
              mid_dot <= 1'b0;
            end else begin
              m_tdata <= sitd_pkg::CH_ZERO + {4'd0, digits[idx]};
              m_tlast <= (idx == '0);
              if (idx == '0) begin
                state <= IDLE;
              end else begin
                idx <= idx - 1'b1;
              end
            end
          end
        end
        SPEC: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata <= spec_ch;
            m_tlast <= (spec_cnt == 2'd0);
            if (spec_cnt == 2'd0) begin
              state <= IDLE;
            end else begin
              spec_cnt <= spec_cnt - 1'b1;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
